### rtl/vcc_pkg.sv
// ----------------------------------------------------------------------------
// vcc_pkg - shared types and constants for the repeating-key character cipher
// Field widths, register indexes and character codes used by all modules.
// ----------------------------------------------------------------------------
package vcc_pkg;

    // Field and register widths
    localparam int CHAR_W     = 8;
    localparam int SHIFT_W    = 5;
    localparam int POS_W      = 4;
    localparam int LEN_W      = 5;
    localparam int SLOTS_W    = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SLOTS_W;
    localparam int IN_USER_W  = 2;

    // Longest key in use
    localparam logic [LEN_W-1:0] KEY_MAX = LEN_W'(16);

    // Configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_KEY_LENGTH     = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_KEY_SLOTS_LOW  = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_KEY_SLOTS_HIGH = t_cfg_idx'(2);

    // Reset values of the configuration registers
    localparam logic [LEN_W-1:0]   KEY_LENGTH_RST     = LEN_W'(1);
    localparam logic [SLOTS_W-1:0] KEY_SLOTS_LOW_RST  = SLOTS_W'(1);
    localparam logic [SLOTS_W-1:0] KEY_SLOTS_HIGH_RST = SLOTS_W'(0);

    // Character codes
    localparam logic [CHAR_W-1:0]  CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0]  CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0]  CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0]  CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0]  CH_NEWLINE = 8'h0A;
    localparam logic [SHIFT_W-1:0] ALPHA      = SHIFT_W'(26);

    // Cipher direction
    typedef enum logic {
        MODE_ENC = 1'b0,
        MODE_DEC = 1'b1
    } t_mode;

    // Per-item payload held between the key stage and the transform stage
    typedef struct packed {
        t_mode               mode;
        logic [CHAR_W-1:0]   chr;
        logic [SHIFT_W-1:0]  shift;
    } t_stage;

endpackage

### rtl/vcc_key_sched.sv
// ----------------------------------------------------------------------------
// vcc_key_sched - key registers and key position counter
// Holds the configuration words, picks the shift for the current item and
// advances the key position on every accepted item.
// ----------------------------------------------------------------------------
module vcc_key_sched (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  vcc_pkg::t_cfg_idx           i_cfg_idx,
    input  logic [vcc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                        i_advance,
    input  logic                        i_restart,
    output logic [vcc_pkg::SHIFT_W-1:0] o_shift
);
    import vcc_pkg::*;

    logic [LEN_W-1:0]   r_key_length;
    logic [SLOTS_W-1:0] r_slots_low;
    logic [SLOTS_W-1:0] r_slots_high;
    logic [POS_W-1:0]   r_pos;
    logic [POS_W-1:0]   n_pos;

    logic [LEN_W-1:0]   eff_len;
    logic [POS_W-1:0]   cur_pos;
    logic [LEN_W-1:0]   pos_inc;
    logic [SLOTS_W-1:0] slot_word;

    // Clamp the key length into 1..KEY_MAX
    always_comb begin
        if (r_key_length == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_key_length > KEY_MAX) begin
            eff_len = KEY_MAX;
        end else begin
            eff_len = r_key_length;
        end
    end

    // Pick the position for this item and the one after it
    always_comb begin
        if (i_restart || ({1'b0, r_pos} >= eff_len)) begin
            cur_pos = '0;
        end else begin
            cur_pos = r_pos;
        end
        pos_inc = {1'b0, cur_pos} + LEN_W'(1);
        if (pos_inc >= eff_len) begin
            n_pos = '0;
        end else begin
            n_pos = pos_inc[POS_W-1:0];
        end
    end

    // Select the five-bit shift slot
    assign slot_word = cur_pos[POS_W-1] ? r_slots_high : r_slots_low;
    assign o_shift   = slot_word[SHIFT_W * cur_pos[POS_W-2:0] +: SHIFT_W];

    // Hold configuration words and advance the position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length <= KEY_LENGTH_RST;
            r_slots_low  <= KEY_SLOTS_LOW_RST;
            r_slots_high <= KEY_SLOTS_HIGH_RST;
            r_pos        <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KEY_LENGTH:     r_key_length <= i_cfg_data[LEN_W-1:0];
                    CFG_KEY_SLOTS_LOW:  r_slots_low  <= i_cfg_data[SLOTS_W-1:0];
                    CFG_KEY_SLOTS_HIGH: r_slots_high <= i_cfg_data[SLOTS_W-1:0];
                    default: ;
                endcase
            end
            if (i_advance) begin
                r_pos <= n_pos;
            end
        end
    end

endmodule

### rtl/vcc_xform.sv
// ----------------------------------------------------------------------------
// vcc_xform - per-character shift
// Letters rotate within their own case, newline passes, other bytes add or
// subtract the raw shift modulo 256.
// ----------------------------------------------------------------------------
module vcc_xform (
    input  vcc_pkg::t_mode              i_mode,
    input  logic [vcc_pkg::CHAR_W-1:0]  i_char,
    input  logic [vcc_pkg::SHIFT_W-1:0] i_shift,
    output logic [vcc_pkg::CHAR_W-1:0]  o_char
);
    import vcc_pkg::*;

    logic               is_upper;
    logic               is_lower;
    logic [CHAR_W-1:0]  base;
    logic [SHIFT_W-1:0] s_red;
    logic [SHIFT_W-1:0] off;
    logic [SHIFT_W:0]   sum;
    logic [SHIFT_W-1:0] new_off;

    assign is_upper = (i_char >= CH_UPPER_A) && (i_char <= CH_UPPER_Z);
    assign is_lower = (i_char >= CH_LOWER_A) && (i_char <= CH_LOWER_Z);
    assign base     = is_upper ? CH_UPPER_A : CH_LOWER_A;

    // Bring the shift into 0..25 and rotate the letter offset
    always_comb begin
        s_red = (i_shift >= ALPHA) ? (i_shift - ALPHA) : i_shift;
        off   = SHIFT_W'(i_char - base);
        if (i_mode == MODE_DEC) begin
            sum = (off >= s_red) ? ({1'b0, off} - {1'b0, s_red})
                                 : ({1'b0, off} + {1'b0, ALPHA} - {1'b0, s_red});
        end else begin
            sum = {1'b0, off} + {1'b0, s_red};
            if (sum >= {1'b0, ALPHA}) begin
                sum = sum - {1'b0, ALPHA};
            end
        end
        new_off = sum[SHIFT_W-1:0];
    end

    // Choose letter, newline or plain byte result
    always_comb begin
        if (i_char == CH_NEWLINE) begin
            o_char = i_char;
        end else if (is_upper || is_lower) begin
            o_char = base + {{(CHAR_W-SHIFT_W){1'b0}}, new_off};
        end else if (i_mode == MODE_DEC) begin
            o_char = i_char - {{(CHAR_W-SHIFT_W){1'b0}}, i_shift};
        end else begin
            o_char = i_char + {{(CHAR_W-SHIFT_W){1'b0}}, i_shift};
        end
    end

endmodule

### rtl/vigenere_char_cipher_core.sv
// ----------------------------------------------------------------------------
// vigenere_char_cipher_core - repeating-key character cipher, one byte a cycle when not stalled
//
// Input stream: s_axis_tdata carries the character, s_axis_tuser carries the
// mode bit (0 encipher, 1 decipher) and the restart flag. Output stream:
// m_axis_tdata carries the transformed character. Every input item gives
// exactly one output item, in order.
// Key setup goes through the write port (i_cfg_we, i_cfg_idx, i_cfg_data):
// index 0 key length, 1 shifts 0..7, 2 shifts 8..15, five bits per shift.
// Write it only while no item is in flight.
// An item passes two register stages, the key stage and then the transform
// stage: the key stage picks the shift and moves the key position, the
// transform stage registers the result. Throughput is one item per cycle
// while the receiver does not stall, set by the two-register pipeline with
// a valid bit per stage.
// When the receiver stalls, the output register holds its item and the
// pipeline keeps filling until both stages are full; s_axis_tready then
// drops. Reset empties the pipeline, sets key length 1, shift slot 0 to 1,
// the rest to 0 and the key position to 0.
// ----------------------------------------------------------------------------
module vigenere_char_cipher_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port
    input  logic                          i_cfg_we,
    input  vcc_pkg::t_cfg_idx             i_cfg_idx,
    input  logic [vcc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [vcc_pkg::CHAR_W-1:0]    s_axis_tdata,   // [7:0] char_in
    input  logic [vcc_pkg::IN_USER_W-1:0] s_axis_tuser,   // [0] mode, [1] restart
    // Output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [vcc_pkg::CHAR_W-1:0]    m_axis_tdata    // [7:0] char_out
);
    import vcc_pkg::*;

    logic               s_accept;
    logic               stage_move;
    logic               out_free;
    logic [SHIFT_W-1:0] key_shift;
    logic [CHAR_W-1:0]  xf_char;

    logic               r_stage_valid;
    t_stage             r_stage;
    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_out_char;

    // Handshake chain: output register frees the stage, stage frees the input
    assign out_free      = !r_out_valid || m_axis_tready;
    assign stage_move    = r_stage_valid && out_free;
    assign s_axis_tready = !r_stage_valid || out_free;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // Key selection and position counter
    vcc_key_sched u_key_sched (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_advance  (s_accept),
        .i_restart  (s_axis_tuser[1]),
        .o_shift    (key_shift)
    );

    // Character transform
    vcc_xform u_xform (
        .i_mode  (r_stage.mode),
        .i_char  (r_stage.chr),
        .i_shift (r_stage.shift),
        .o_char  (xf_char)
    );

    // Capture the item with its shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_stage_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_stage.mode  <= t_mode'(s_axis_tuser[0]);
            r_stage.chr   <= s_axis_tdata;
            r_stage.shift <= key_shift;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_stage_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_move) begin
            r_out_char <= xf_char;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_char;

endmodule
